[rtl/multiset_bag_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// multiset_bag_table_unit_defines.svh
// Assertion macros shared by the bag table RTL modules.
// ----------------------------------------------------------------------------
`ifndef MULTISET_BAG_TABLE_UNIT_DEFINES_SVH
`define MULTISET_BAG_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MSBT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MSBT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/msbt_pkg.sv]
// ----------------------------------------------------------------------------
// msbt_pkg
// Shared types and constants for the bag table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msbt_pkg;

  // Field widths of the stream payloads
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned VALUE_IN_W = 32;
  localparam int unsigned FREQ_W     = 8;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned OUT_W      = 16;

  // Frequency reported for a query on an empty bag (-1)
  localparam logic [FREQ_W-1:0] FREQ_EMPTY = 8'hFF;

  // Request operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch request, reset scan state
    logic scan;    // walk the stored entries
    logic finish;  // commit state, load result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // all entries read and processed
    logic out_free;   // result register can take a new result
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/msbt_ctrl.sv]
// ----------------------------------------------------------------------------
// msbt_ctrl
// Request sequencer: accepts a request, runs the entry scan when the
// operation needs one, then commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiset_bag_table_unit_defines.svh"

module msbt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire msbt_pkg::op_t        func,
  input  wire msbt_pkg::dp_stat_t   stat,
  output msbt_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Handshake and commands
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign cmd.load   = accept;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.finish = (state == ST_FINISH) && stat.out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == msbt_pkg::OP_REMOVE || func == msbt_pkg::OP_QUERY) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  `MSBT_ASSERT_NEXT(a_finish_to_idle, cmd.finish, s_tready, "no return to idle after commit")
  `MSBT_ASSERT_NEXT(a_no_scan_skip,
    accept && (func == msbt_pkg::OP_ADD || func == msbt_pkg::OP_CLEAR),
    state == ST_FINISH, "add or clear entered the scan")
  `MSBT_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state), "controller state not one-hot")

endmodule

`default_nettype wire

[rtl/msbt_dp.sv]
// ----------------------------------------------------------------------------
// msbt_dp
// Bag datapath: entry memory, entry count, scan counter with registered
// read, match tally, remove compaction and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiset_bag_table_unit_defines.svh"

module msbt_dp #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire msbt_pkg::ctrl_cmd_t                cmd,
  output msbt_pkg::dp_stat_t                      stat,
  input  wire msbt_pkg::op_t                      func,
  input  wire logic [msbt_pkg::VALUE_IN_W-1:0]    entry_value,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [msbt_pkg::OUT_W-1:0]              m_tdata
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Request registers
  msbt_pkg::op_t              op;
  logic [VALUE_WIDTH-1:0]     value;
  logic [VALUE_WIDTH+msbt_pkg::VALUE_IN_W-1:0] value_ext;

  // Bag state
  logic [VALUE_WIDTH-1:0]     mem [CAPACITY];
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;

  // Scan state
  logic [CW-1:0]              idx;
  logic                       rd_vld;
  logic [AW-1:0]              rd_idx;
  logic [VALUE_WIDTH-1:0]     rd_data;
  logic [CW-1:0]              tally;
  logic                       found;
  logic                       issue;
  logic                       match;
  logic                       shift_wr;
  logic                       add_wr;
  logic                       not_full;

  // Result fields
  logic                               res_ok;
  logic [msbt_pkg::FREQ_W-1:0]        res_freq;
  logic [CW+msbt_pkg::FREQ_W-1:0]     tally_ext;
  logic [CW+msbt_pkg::SIZE_W-1:0]     size_ext;

  // Only the low VALUE_WIDTH bits of the request value count
  assign value_ext = {{VALUE_WIDTH{1'b0}}, entry_value};

  assign not_full = (count < CAP_C);
  assign issue    = cmd.scan && (idx < count);
  assign match    = rd_vld && (rd_data == value);
  assign shift_wr = rd_vld && found && (op == msbt_pkg::OP_REMOVE);
  assign add_wr   = cmd.finish && (op == msbt_pkg::OP_ADD) && not_full;

  assign stat.scan_done = cmd.scan && !issue && !rd_vld;
  assign stat.out_free  = !m_tvalid || m_tready;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (shift_wr) begin
      mem[rd_idx - AW'(1)] <= rd_data;
    end else if (add_wr) begin
      mem[count[AW-1:0]] <= value;
    end
    if (issue) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= func;
      value <= value_ext[VALUE_WIDTH-1:0];
    end
  end

  // Scan counter, read pipeline, tally and first-match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      tally  <= '0;
      found  <= 1'b0;
    end else if (cmd.load) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      tally  <= '0;
      found  <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        idx <= idx + CW'(1);
      end
      if (match && op == msbt_pkg::OP_QUERY) begin
        tally <= tally + CW'(1);
      end
      if (match && op == msbt_pkg::OP_REMOVE) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= idx[AW-1:0];
    end
  end

  // Commit: new count and result fields
  always_comb begin
    count_next = count;
    res_ok     = 1'b0;
    res_freq   = '0;
    case (op)
      msbt_pkg::OP_ADD: begin
        res_ok = not_full;
        if (not_full) begin
          count_next = count + CW'(1);
        end
      end
      msbt_pkg::OP_REMOVE: begin
        res_ok = found;
        if (found) begin
          count_next = count - CW'(1);
        end
      end
      msbt_pkg::OP_CLEAR: begin
        res_ok     = 1'b1;
        count_next = '0;
      end
      msbt_pkg::OP_QUERY: begin
        res_ok   = (tally != '0);
        res_freq = (count == '0) ? msbt_pkg::FREQ_EMPTY
                                 : tally_ext[msbt_pkg::FREQ_W-1:0];
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign tally_ext = {{msbt_pkg::FREQ_W{1'b0}}, tally};
  assign size_ext  = {{msbt_pkg::SIZE_W{1'b0}}, count_next};

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  // Result register: holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {size_ext[msbt_pkg::SIZE_W-1:0], res_freq, res_ok};
    end
  end

  // Checks
  `MSBT_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "entry count above capacity")
  `MSBT_ASSERT_NOW(a_found_remove, found, op == msbt_pkg::OP_REMOVE, "match flag outside remove")
  `MSBT_ASSERT_NOW(a_shift_addr, shift_wr, rd_idx != '0, "compaction write below entry zero")

endmodule

`default_nettype wire

[rtl/multiset_bag_table_unit.sv]
// ----------------------------------------------------------------------------
// multiset_bag_table_unit
// Fixed-capacity bag of values kept packed in arrival order, with add,
// remove (first equal entry, later entries shift down), clear and query.
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  tuser: func; tdata: entry_value
//   m_*       out  m_tvalid/m_tready  tdata: ok, frequency, bag_size
//
// Add and clear skip the scan and go from the accept to the commit.
// Remove and query read the n stored entries one per cycle through the single
// memory read port, then commit; the result is registered at the commit, and the
// sequencer then returns to idle to take the next request.
// A new request is accepted once the previous one has committed; a result
// still waiting in the output register holds the next commit, not the accept.
// Reset empties the bag at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_bag_table_unit #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] entry_value
  input  wire logic [1:0]  s_tuser,   // [1:0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [0] ok, [8:1] frequency, [15:9] bag_size
);

  msbt_pkg::ctrl_cmd_t cmd;
  msbt_pkg::dp_stat_t  stat;
  msbt_pkg::op_t       func;

  assign func = msbt_pkg::op_t'(s_tuser);

  // Sequencer
  msbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path
  msbt_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .entry_value (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire

[verif/bag_result_checker.sv]
// ----------------------------------------------------------------------------
// bag_result_checker
// Watches both stream channels of the bag table unit. Every accepted request
// updates a private copy of the bag and queues the result it must produce.
// Every accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module bag_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [msbt_pkg::VALUE_IN_W-1:0] s_tdata,
  input  logic [msbt_pkg::FUNC_W-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [msbt_pkg::OUT_W-1:0]      m_tdata,
  output int                              mismatch_count,
  output int                              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BAG_CAPACITY = 64;

  typedef struct packed {
    logic                        ok;
    logic [msbt_pkg::FREQ_W-1:0] frequency;
    logic [msbt_pkg::SIZE_W-1:0] bag_size;
  } bag_result_t;

  // Private copy of the bag
  logic [msbt_pkg::VALUE_IN_W-1:0] bag_entries [BAG_CAPACITY];
  int unsigned                     bag_count;
  bag_result_t                     expected_results [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    bag_count       = 0;
  end

  // Apply one request to the bag copy and return the result it produces
  function automatic bag_result_t apply_bag_request(
    msbt_pkg::op_t                   op,
    logic [msbt_pkg::VALUE_IN_W-1:0] value
  );
    bag_result_t res;
    int unsigned pos;
    int unsigned hits;
    int unsigned i;
    res = '0;
    case (op)
      msbt_pkg::OP_ADD: begin
        if (bag_count < BAG_CAPACITY) begin
          bag_entries[bag_count] = value;
          bag_count++;
          res.ok = 1'b1;
        end
      end
      msbt_pkg::OP_REMOVE: begin
        // first equal entry, later entries move down one place
        pos = bag_count;
        for (i = 0; i < bag_count; i++)
          if (pos == bag_count && bag_entries[i] == value) pos = i;
        if (pos < bag_count) begin
          for (i = pos; i + 1 < bag_count; i++)
            bag_entries[i] = bag_entries[i + 1];
          bag_count--;
          res.ok = 1'b1;
        end
      end
      msbt_pkg::OP_CLEAR: begin
        bag_count = 0;
        res.ok    = 1'b1;
      end
      msbt_pkg::OP_QUERY: begin
        if (bag_count == 0) begin
          res.frequency = msbt_pkg::FREQ_EMPTY;
        end else begin
          hits = 0;
          for (i = 0; i < bag_count; i++)
            if (bag_entries[i] == value) hits++;
          res.frequency = hits[msbt_pkg::FREQ_W-1:0];
          res.ok        = (hits != 0);
        end
      end
      default: ;
    endcase
    res.bag_size = bag_count[msbt_pkg::SIZE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, int expected_val, int actual_val);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d",
             $time, field, expected_val, actual_val);
  endtask

  // Results are checked before the request of the same edge is queued
  always @(posedge clk) begin
    bag_result_t exp_res;
    bag_result_t act_res;
    if (rst) begin
      expected_results.delete();
      bag_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        act_res.ok        = m_tdata[0];
        act_res.frequency = m_tdata[8:1];
        act_res.bag_size  = m_tdata[15:9];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          exp_res = expected_results.pop_front();
          if (act_res.ok !== exp_res.ok)
            report_mismatch("ok", exp_res.ok, act_res.ok);
          if (act_res.frequency !== exp_res.frequency)
            report_mismatch("frequency", $signed(exp_res.frequency),
                            $signed(act_res.frequency));
          if (act_res.bag_size !== exp_res.bag_size)
            report_mismatch("bag_size", exp_res.bag_size, act_res.bag_size);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                apply_bag_request(msbt_pkg::op_t'(s_tuser), s_tdata));
    end
    pending_results = expected_results.size();
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives request transactions into the bag table unit with random gaps and
// output back-pressure, including one long stall that fills the block. A
// directed opening hits the corner cases; random segments then fill, grow,
// shrink and query the bag. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS    = 950;
  localparam int QUIET_TAIL     = 120;
  localparam int BAG_DEPTH      = 64;
  localparam int HOLD_AFTER     = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [msbt_pkg::VALUE_IN_W-1:0] s_tdata  = '0;
  logic [msbt_pkg::FUNC_W-1:0]     s_tuser  = msbt_pkg::OP_ADD;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [msbt_pkg::OUT_W-1:0]      m_tdata;

  int mismatch_count;
  int pending_results;
  int requests_taken = 0;
  int idle_cycles    = 0;
  int items_sent     = 0;
  bit quiet_tail     = 1'b0;
  bit hold_done      = 1'b0;

  logic [msbt_pkg::VALUE_IN_W-1:0] value_pool [6];
  logic [msbt_pkg::VALUE_IN_W-1:0] added_values [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multiset_bag_table_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bag_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (s_tvalid && s_tready) requests_taken++;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** multiset_bag_table_unit: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin
    @(negedge clk);
    forever begin
      if (!hold_done && requests_taken >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // One request transaction, then maybe a gap; called at a falling edge
  task automatic send_request(msbt_pkg::op_t op, logic [msbt_pkg::VALUE_IN_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    quiet_tail = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
    if (op == msbt_pkg::OP_ADD && added_values.size() < BAG_DEPTH)
      added_values.insert(added_values.size(), value);
    if (op == msbt_pkg::OP_CLEAR) added_values.delete();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  function automatic logic [msbt_pkg::VALUE_IN_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return value_pool[$urandom_range(0, 5)];
    endcase
  endfunction

  // Mostly a value believed to be stored, sometimes anything
  function automatic logic [msbt_pkg::VALUE_IN_W-1:0] pick_known_value();
    if (added_values.size() > 0 && $urandom_range(0, 4) != 0)
      return added_values[$urandom_range(0, added_values.size() - 1)];
    return pick_value();
  endfunction

  task automatic remove_known();
    int idx;
    logic [msbt_pkg::VALUE_IN_W-1:0] value;
    if (added_values.size() > 0 && $urandom_range(0, 4) != 0) begin
      idx   = $urandom_range(0, added_values.size() - 1);
      value = added_values[idx];
      added_values.delete(idx);
    end else begin
      value = pick_value();
    end
    send_request(msbt_pkg::OP_REMOVE, value);
  endtask

  task automatic send_noise();
    send_request(msbt_pkg::op_t'($urandom_range(0, 3)), $urandom());
  endtask

  initial begin
    int seg_kind;
    int seg_len;
    int r;
    foreach (value_pool[i]) value_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: empty bag, extremes, duplicates, shifts, stale store
    send_request(msbt_pkg::OP_QUERY,  32'h0000_0000);
    send_request(msbt_pkg::OP_REMOVE, 32'h0000_0005);
    send_request(msbt_pkg::OP_CLEAR,  32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_ADD,    32'h0000_0000);
    send_request(msbt_pkg::OP_ADD,    32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_ADD,    32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_ADD,    32'h1234_5678);
    send_request(msbt_pkg::OP_QUERY,  32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_QUERY,  32'h0000_0000);
    send_request(msbt_pkg::OP_QUERY,  32'hDEAD_BEEF);
    send_request(msbt_pkg::OP_REMOVE, 32'hDEAD_BEEF);
    send_request(msbt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_QUERY,  32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_REMOVE, 32'h0000_0000);
    send_request(msbt_pkg::OP_REMOVE, 32'h1234_5678);
    send_request(msbt_pkg::OP_QUERY,  32'h1234_5678);
    send_request(msbt_pkg::OP_CLEAR,  32'h0000_0000);
    send_request(msbt_pkg::OP_QUERY,  32'h0000_0000);
    send_request(msbt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_request(msbt_pkg::OP_ADD,    32'hA5A5_A5A5);
    send_request(msbt_pkg::OP_QUERY,  32'hA5A5_A5A5);

    // Random segments; the first one always fills the bag past capacity
    seg_kind = 0;
    while (items_sent < TOTAL_ITEMS) begin
      seg_len = $urandom_range(8, 40);
      if ($urandom_range(0, 1) == 0)
        foreach (value_pool[i]) value_pool[i] = $urandom();
      case (seg_kind)
        0, 1: begin
          if ($urandom_range(0, 1) == 0) send_request(msbt_pkg::OP_CLEAR, $urandom());
          repeat (BAG_DEPTH + 4) send_request(msbt_pkg::OP_ADD, pick_value());
          repeat (4) send_request(msbt_pkg::OP_QUERY, pick_known_value());
        end
        2, 3, 4: begin
          repeat (seg_len) begin
            r = $urandom_range(0, 9);
            if (r < 6)      send_request(msbt_pkg::OP_ADD, pick_value());
            else if (r < 8) send_request(msbt_pkg::OP_QUERY, pick_known_value());
            else if (r < 9) remove_known();
            else            send_noise();
          end
        end
        5, 6, 7: begin
          repeat (seg_len) begin
            r = $urandom_range(0, 9);
            if (r < 5)      remove_known();
            else if (r < 8) send_request(msbt_pkg::OP_QUERY, pick_known_value());
            else if (r < 9) send_request(msbt_pkg::OP_ADD, pick_value());
            else            send_noise();
          end
        end
        8: begin
          repeat (seg_len) begin
            if ($urandom_range(0, 3) != 0)
              send_request(msbt_pkg::OP_QUERY, pick_known_value());
            else
              send_request(msbt_pkg::OP_ADD, pick_value());
          end
        end
        default: begin
          repeat (seg_len) send_noise();
        end
      endcase
      seg_kind = $urandom_range(0, 9);
    end
    s_tvalid <= 1'b0;

    // Drain, then let any stray result show up
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("** multiset_bag_table_unit: PASSED **");
    else
      $display("** multiset_bag_table_unit: FAILED **");
    $finish;
  end

endmodule
